FILE: design/assert_macros.svh
// Assertion helpers for the health monitor. All checks are sampled on clk_i
// and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define HTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent must never hold outside reset.
`define HTM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define HTM_ASSERT(label, prop, msg)
`define HTM_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: design/htm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htm_pkg;

  localparam int unsigned NOW_W    = 48;
  localparam int unsigned TEMP_W   = 9;
  localparam int unsigned MEM_W    = 8;
  localparam int unsigned DISK_W   = 17;
  localparam int unsigned FPS_W    = 11;
  localparam int unsigned RATIO_W  = 17;
  localparam int unsigned SEC_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned MS_PER_SEC = 1000;
  // 65535 s * 1000 fits in 26 bits
  localparam int unsigned SUS_MS_W   = 26;
  // 10-bit target * 16-bit ratio
  localparam int unsigned PROD_W     = 26;
  // Q1.15 ratio: fps is scaled by 2^15 before the compare
  localparam int unsigned RATIO_FRAC = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_TEMP_WARN    = 3'd0,
    CFG_MEM_PERCENT_WARN = 3'd1,
    CFG_MEM_SUSTAIN_SEC  = 3'd2,
    CFG_DISK_STOP_GB     = 3'd3,
    CFG_DISK_WARN_GB     = 3'd4,
    CFG_FPS_TARGET       = 3'd5,
    CFG_FPS_RATIO        = 3'd6,
    CFG_FPS_SUSTAIN_SEC  = 3'd7
  } htm_cfg_e;

  typedef struct packed {
    logic        [NOW_W-1:0]  now_ms;
    logic signed [TEMP_W-1:0] cpu_temp;
    logic signed [MEM_W-1:0]  mem_percent;
    logic signed [DISK_W-1:0] disk_free_gb;
    logic signed [FPS_W-1:0]  capture_fps;
  } htm_sample_t;

endpackage

`default_nettype wire

FILE: design/htm_sustain.sv
`timescale 1ns / 1ps
`default_nettype none

// Duration qualifier: holds the time a violation started and flags once it
// has lasted the programmed number of milliseconds.
module htm_sustain
  import htm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 viol_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [SUS_MS_W-1:0]  sustain_ms_i,
  output logic                      hit_o
);

  logic [TIME_BITS-1:0] anchor_q, anchor_d;
  logic                 set_q, set_d;
  logic [TIME_BITS-1:0] anchor_eff;
  logic [TIME_BITS-1:0] elapsed;

  // A fresh violation anchors at the current sample.
  assign anchor_eff = set_q ? anchor_q : now_i;
  assign elapsed    = now_i - anchor_eff;

  // Time running backwards never counts as elapsed.
  assign hit_o = viol_i && (now_i >= anchor_eff) &&
                 (elapsed >= TIME_BITS'(sustain_ms_i));

  always_comb begin
    anchor_d = anchor_q;
    set_d    = set_q;
    if (step_i) begin
      if (!viol_i) begin
        anchor_d = '0;
        set_d    = 1'b0;
      end else begin
        anchor_d = anchor_eff;
        set_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
      set_q    <= 1'b0;
    end else begin
      anchor_q <= anchor_d;
      set_q    <= set_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/health_threshold_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Health threshold monitor. Each input beat is one poll sample (ms timestamp,
// temperature, memory percent, free disk, capture frame rate); each sample
// yields exactly one result beat with stop_fault, warn_active, a health report
// flag and code, and the new degraded state. A negative metric means unknown
// and skips its rule; a negative threshold disables its rule. Temperature
// warns at once, disk has a stop tier (fault) and a warn tier, and memory-high
// and frame-rate-low warn only after holding for their sustain time. A report
// with code 1 goes out when a warning appears while healthy, code 0 when the
// block returns to clean. Throughput is one sample per clock while out_ready_i
// does not stall the result channel; each sample passes the input register and
// then the result register. Detector state (anchors, degraded flag) is updated
// as a sample moves from the input register into the result register, so the
// following sample always sees it. Configuration writes (cfg_ready_o is always
// high) are meant for idle periods; the sustain times in ms and the frame-rate
// product target*ratio are precomputed on the write, so the per-sample path is
// only compares and one time subtract per sustain rule.
module health_threshold_monitor
  import htm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  // sample channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [NOW_W-1:0]         now_ms_i,
  input  wire logic signed [TEMP_W-1:0] cpu_temp_i,
  input  wire logic signed [MEM_W-1:0]  mem_percent_i,
  input  wire logic signed [DISK_W-1:0] disk_free_gb_i,
  input  wire logic signed [FPS_W-1:0]  capture_fps_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          stop_fault_o,
  output logic                          warn_active_o,
  output logic                          report_valid_o,
  output logic                          report_code_o,
  output logic                          degraded_now_o
);

  `include "assert_macros.svh"

  localparam logic [SUS_MS_W-1:0] MEM_SUS_RST = SUS_MS_W'(10 * MS_PER_SEC);
  localparam logic [SUS_MS_W-1:0] FPS_SUS_RST = SUS_MS_W'(3 * MS_PER_SEC);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0]  cpu_temp_warn_q;
  logic signed [MEM_W-1:0]   mem_percent_warn_q;
  logic signed [DISK_W-1:0]  disk_stop_gb_q;
  logic signed [DISK_W-1:0]  disk_warn_gb_q;
  logic signed [FPS_W-1:0]   fps_target_q;
  logic signed [RATIO_W-1:0] fps_ratio_q;
  logic [SUS_MS_W-1:0]       mem_sus_ms_q;
  logic [SUS_MS_W-1:0]       fps_sus_ms_q;
  // target * ratio; only meaningful while both are non-negative
  logic [PROD_W-1:0]         fps_prod_q;

  logic cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_temp_warn_q    <= '1;
      mem_percent_warn_q <= MEM_W'(85);
      disk_stop_gb_q     <= DISK_W'(1);
      disk_warn_gb_q     <= DISK_W'(10);
      fps_target_q       <= '1;
      fps_ratio_q        <= '1;
      mem_sus_ms_q       <= MEM_SUS_RST;
      fps_sus_ms_q       <= FPS_SUS_RST;
      fps_prod_q         <= '0;
    end else if (cfg_fire) begin
      unique case (htm_cfg_e'(cfg_index_i))
        CFG_CPU_TEMP_WARN:    cpu_temp_warn_q    <= cfg_data_i[TEMP_W-1:0];
        CFG_MEM_PERCENT_WARN: mem_percent_warn_q <= cfg_data_i[MEM_W-1:0];
        CFG_MEM_SUSTAIN_SEC: begin
          mem_sus_ms_q <= SUS_MS_W'(cfg_data_i[SEC_W-1:0]) * SUS_MS_W'(MS_PER_SEC);
        end
        CFG_DISK_STOP_GB:     disk_stop_gb_q     <= cfg_data_i[DISK_W-1:0];
        CFG_DISK_WARN_GB:     disk_warn_gb_q     <= cfg_data_i[DISK_W-1:0];
        CFG_FPS_TARGET: begin
          fps_target_q <= cfg_data_i[FPS_W-1:0];
          fps_prod_q   <= PROD_W'(cfg_data_i[FPS_W-2:0]) *
                          PROD_W'(fps_ratio_q[RATIO_W-2:0]);
        end
        CFG_FPS_RATIO: begin
          fps_ratio_q <= cfg_data_i[RATIO_W-1:0];
          fps_prod_q  <= PROD_W'(fps_target_q[FPS_W-2:0]) *
                         PROD_W'(cfg_data_i[RATIO_W-2:0]);
        end
        CFG_FPS_SUSTAIN_SEC: begin
          fps_sus_ms_q <= SUS_MS_W'(cfg_data_i[SEC_W-1:0]) * SUS_MS_W'(MS_PER_SEC);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input register -> result register
  // ---------------------------------------------------------------------------
  htm_sample_t smp_q;
  logic        smp_valid_q, smp_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        in_fire;
  logic        advance;

  // A sample leaves the input register whenever the result slot is free or
  // its current beat is being taken.
  assign advance    = smp_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !smp_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    smp_valid_d = smp_valid_q;
    if (in_fire) begin
      smp_valid_d = 1'b1;
    end else if (advance) begin
      smp_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      smp_valid_q <= smp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q.now_ms       <= now_ms_i;
      smp_q.cpu_temp     <= cpu_temp_i;
      smp_q.mem_percent  <= mem_percent_i;
      smp_q.disk_free_gb <= disk_free_gb_i;
      smp_q.capture_fps  <= capture_fps_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Rule evaluation on the registered sample
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] now_t;
  logic                 temp_warn;
  logic                 mem_over;
  logic                 mem_hit;
  logic                 disk_stop;
  logic                 disk_warn;
  logic [PROD_W-1:0]    fps_scaled;
  logic                 fps_low;
  logic                 fps_hit;
  logic                 warn;
  logic                 deg_now;
  logic                 rep_valid;
  logic                 rep_code;
  logic                 degraded_q;

  // Timestamp is reduced (or widened) to the configured time width.
  assign now_t = TIME_BITS'(smp_q.now_ms);

  assign temp_warn = !cpu_temp_warn_q[TEMP_W-1] && !smp_q.cpu_temp[TEMP_W-1] &&
                     (smp_q.cpu_temp > cpu_temp_warn_q);

  assign mem_over = !mem_percent_warn_q[MEM_W-1] && !smp_q.mem_percent[MEM_W-1] &&
                    (smp_q.mem_percent > mem_percent_warn_q);

  // Warn tier is only looked at when the stop tier stays quiet.
  assign disk_stop = !smp_q.disk_free_gb[DISK_W-1] && !disk_stop_gb_q[DISK_W-1] &&
                     (smp_q.disk_free_gb < disk_stop_gb_q);
  assign disk_warn = !smp_q.disk_free_gb[DISK_W-1] && !disk_stop &&
                     !disk_warn_gb_q[DISK_W-1] &&
                     (smp_q.disk_free_gb < disk_warn_gb_q);

  // fps * 2^15 < target * ratio, exact in integers
  assign fps_scaled = PROD_W'(smp_q.capture_fps[FPS_W-2:0]) << RATIO_FRAC;
  assign fps_low    = !fps_target_q[FPS_W-1] && !fps_ratio_q[RATIO_W-1] &&
                      !smp_q.capture_fps[FPS_W-1] && (fps_scaled < fps_prod_q);

  htm_sustain #(
    .TIME_BITS   (TIME_BITS)
  ) u_mem_sustain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .viol_i       (mem_over),
    .now_i        (now_t),
    .sustain_ms_i (mem_sus_ms_q),
    .hit_o        (mem_hit)
  );

  htm_sustain #(
    .TIME_BITS   (TIME_BITS)
  ) u_fps_sustain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .viol_i       (fps_low),
    .now_i        (now_t),
    .sustain_ms_i (fps_sus_ms_q),
    .hit_o        (fps_hit)
  );

  assign warn    = temp_warn || mem_hit || disk_warn || fps_hit;
  assign deg_now = warn || disk_stop;

  // A stop fault on its own degrades the block silently; recovery from any
  // degraded state is still reported.
  always_comb begin
    priority if (warn && !degraded_q) begin
      rep_valid = 1'b1;
      rep_code  = 1'b1;
    end else if (!deg_now && degraded_q) begin
      rep_valid = 1'b1;
      rep_code  = 1'b0;
    end else begin
      rep_valid = 1'b0;
      rep_code  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degraded_q <= 1'b0;
    end else if (advance) begin
      degraded_q <= deg_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic stop_fault_q;
  logic warn_active_q;
  logic report_valid_q;
  logic report_code_q;
  logic degraded_now_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stop_fault_q   <= disk_stop;
      warn_active_q  <= warn;
      report_valid_q <= rep_valid;
      report_code_q  <= rep_code;
      degraded_now_q <= deg_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stop_fault_o   = stop_fault_q;
  assign warn_active_o  = warn_active_q;
  assign report_valid_o = report_valid_q;
  assign report_code_o  = report_code_q;
  assign degraded_now_o = degraded_now_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HTM_ASSERT(a_deg_is_or,
              out_valid_o |-> (degraded_now_o == (stop_fault_o || warn_active_o)),
              "degraded_now_o disagrees with fault and warning")
  `HTM_ASSERT_NEVER(a_recover_clean,
                    out_valid_o && report_valid_o && !report_code_o && degraded_now_o,
                    "recovery report while still degraded")
  `HTM_ASSERT(a_stall_cause,
              !in_ready_o |-> (smp_valid_q && out_valid_q && !out_ready_i),
              "input stalled without a full pipeline")
  `HTM_ASSERT(a_deg_tracks,
              advance |=> (degraded_q == degraded_now_o),
              "degraded flag not taken from last result")

endmodule

`default_nettype wire
